/* rtl/core/hmi_serial_frame_receiver_unit_macros.svh */
// ---------------------------------------------------------------------------
// hmi serial frame receiver assertion macros
// concurrent checks, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef HMI_SERIAL_FRAME_RECEIVER_UNIT_MACROS_SVH
`define HMI_SERIAL_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define HMI_SFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HMI_SFR_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define HMI_SFR_ASSERT(lbl, clk, rstn, prop, msg)
`define HMI_SFR_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

/* rtl/core/hmi_sfr_pkg.sv */
// ---------------------------------------------------------------------------
// hmi serial frame receiver package
// frame sizing, byte codes, event kinds and shared structs
// ---------------------------------------------------------------------------
`default_nettype none

package hmi_sfr_pkg;

  localparam int FRAME_DEPTH = 16;
  localparam int LEN_W       = $clog2(FRAME_DEPTH + 1);
  localparam int HEAD_N      = 4;
  localparam int PEND_W      = 2;

  localparam logic [LEN_W:0]    DEPTH_X   = (LEN_W + 1)'(FRAME_DEPTH);
  localparam logic [PEND_W-1:0] PEND_LAST = PEND_W'(2);

  localparam logic [7:0] END_BYTE    = 8'hFF;
  localparam logic [7:0] CODE_READY  = 8'h88;
  localparam logic [7:0] CODE_TOUCH  = 8'h65;
  localparam logic [7:0] CODE_DEMO0  = 8'h5A;
  localparam logic [7:0] CODE_DEMO1  = 8'hA5;
  localparam logic [7:0] CODE_TOGGLE = 8'h01;
  localparam logic [7:0] CODE_RESET  = 8'h02;

  localparam logic [LEN_W-1:0] LEN_READY = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_DEMO  = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_TOUCH = LEN_W'(4);

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_READY       = 3'd1,
    EV_TOUCH       = 3'd2,
    EV_DEMO_TOGGLE = 3'd3,
    EV_DEMO_RESET  = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [LEN_W-1:0]         len;
    logic [PEND_W-1:0]        pending;
    logic [HEAD_N-1:0][7:0]   head;
  } frame_snap_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  page;
    logic [7:0]  widget;
    logic [7:0]  press;
  } event_t;

endpackage

`default_nettype wire

/* rtl/core/hmi_sfr_if.sv */
// ---------------------------------------------------------------------------
// hmi serial frame receiver channels
// valid/ready byte input channel and event output channel
// ---------------------------------------------------------------------------
`default_nettype none

interface hmi_sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hmi_sfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] page_number;
  logic [7:0] widget_number;
  logic [7:0] press_kind;

  modport source (output valid, output event_kind, output page_number,
                  output widget_number, output press_kind, input ready);
  modport sink   (input valid, input event_kind, input page_number,
                  input widget_number, input press_kind, output ready);
endinterface

`default_nettype wire

/* rtl/core/hmi_sfr_frame.sv */
// ---------------------------------------------------------------------------
// hmi sfr frame tracker
// frame length, pending end-byte run and the leading frame bytes
// ---------------------------------------------------------------------------
`default_nettype none

module hmi_sfr_frame
  import hmi_sfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  rx_byte,
  output frame_snap_t      snap,
  output logic             term
);

  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [PEND_W-1:0]      pend_r, pend_nxt;
  logic [HEAD_N-1:0][7:0] head_r, head_nxt;

  logic [LEN_W:0]   sum;
  logic [LEN_W-1:0] l1;
  logic             fits;
  logic             is_end;

  assign is_end = (rx_byte == END_BYTE);
  assign term   = is_end && (pend_r == PEND_LAST);

  // pending end bytes go in first, clipped at the frame depth
  assign sum  = {1'b0, len_r} + (LEN_W + 1)'(pend_r);
  assign l1   = (sum > DEPTH_X) ? DEPTH_X[LEN_W-1:0] : sum[LEN_W-1:0];
  assign fits = ({1'b0, l1} < DEPTH_X);

  always_comb begin
    logic [LEN_W-1:0] idx;
    len_nxt  = len_r;
    pend_nxt = pend_r;
    head_nxt = head_r;
    idx      = '0;
    if (take) begin
      if (is_end) begin
        if (term) begin
          len_nxt  = '0;
          pend_nxt = '0;
        end else begin
          pend_nxt = pend_r + PEND_W'(1);
        end
      end else begin
        for (int i = 0; i < HEAD_N; i++) begin
          idx = LEN_W'(i);
          if (idx >= len_r && idx < l1) begin
            head_nxt[i] = END_BYTE;
          end else if (idx == l1 && fits) begin
            head_nxt[i] = rx_byte;
          end
        end
        // full frame drops the byte and starts over
        len_nxt  = fits ? (l1 + LEN_W'(1)) : '0;
        pend_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      pend_r <= '0;
    end else begin
      len_r  <= len_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
  end

  assign snap.len     = len_r;
  assign snap.pending = pend_r;
  assign snap.head    = head_r;

endmodule

`default_nettype wire

/* rtl/core/hmi_sfr_decode.sv */
// ---------------------------------------------------------------------------
// hmi sfr frame decoder
// maps a completed frame to its event kind and touch fields
// ---------------------------------------------------------------------------
`default_nettype none

module hmi_sfr_decode
  import hmi_sfr_pkg::*;
(
  input  wire frame_snap_t snap,
  output event_t           ev
);

  always_comb begin
    ev.kind   = EV_NONE;
    ev.page   = '0;
    ev.widget = '0;
    ev.press  = '0;
    if (snap.len == LEN_READY && snap.head[0] == CODE_READY) begin
      ev.kind = EV_READY;
    end else if (snap.len == LEN_TOUCH && snap.head[0] == CODE_TOUCH) begin
      ev.kind   = EV_TOUCH;
      ev.page   = snap.head[1];
      ev.widget = snap.head[2];
      ev.press  = snap.head[3];
    end else if (snap.len == LEN_DEMO && snap.head[0] == CODE_DEMO0
                 && snap.head[1] == CODE_DEMO1) begin
      if (snap.head[2] == CODE_TOGGLE) begin
        ev.kind = EV_DEMO_TOGGLE;
      end else if (snap.head[2] == CODE_RESET) begin
        ev.kind = EV_DEMO_RESET;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hmi_serial_frame_receiver_unit.sv */
// ---------------------------------------------------------------------------
// hmi serial frame receiver unit
// parses a byte stream into display events, frames end with three 0xff bytes
// ---------------------------------------------------------------------------
// usage:
//   in_ch  : one received serial byte per beat (valid/ready)
//   out_ch : one event beat per completed frame: kind, page, widget, press
//   a byte is registered on acceptance and processed from the input register;
//   the event of a frame is registered in the output register when its third
//   0xff byte is processed, and drives out_ch from there
//   throughput is one byte per cycle unless a terminating byte waits, set by
//   the single input register feeding the frame tracker and a single output register
//   bytes that end no frame never wait on the output side; a terminating
//   byte waits in the input register while an earlier event is not taken,
//   and in_ch.ready drops for that time
//   reset (synchronous, rst_n low) empties the frame, clears the pending
//   0xff run and drops any staged byte or event
// ---------------------------------------------------------------------------
`default_nettype none

`include "hmi_serial_frame_receiver_unit_macros.svh"

module hmi_serial_frame_receiver_unit
  import hmi_sfr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  hmi_sfr_in_if.sink     in_ch,
  hmi_sfr_out_if.source  out_ch
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  event_t      out_r;

  logic        out_free;
  logic        proc;
  logic        term;
  frame_snap_t snap;
  event_t      ev;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign proc        = in_valid_r && (!term || out_free);
  assign in_ch.ready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  hmi_sfr_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (proc),
    .rx_byte (in_byte_r),
    .snap    (snap),
    .term    (term)
  );

  hmi_sfr_decode u_decode (
    .snap (snap),
    .ev   (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && term) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && term) begin
      out_r <= ev;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_kind    = out_r.kind;
  assign out_ch.page_number   = out_r.page;
  assign out_ch.widget_number = out_r.widget;
  assign out_ch.press_kind    = out_r.press;

  `HMI_SFR_ASSERT_NEVER(a_pend_range, clk, rst_n, snap.pending == 2'd3, "end run overflow")
  `HMI_SFR_ASSERT_NEVER(a_len_range, clk, rst_n, {1'b0, snap.len} > DEPTH_X, "frame overrun")
  `HMI_SFR_ASSERT(a_term_clears, clk, rst_n, proc && term |=> snap.len == '0 && snap.pending == '0, "frame not cleared")
  `HMI_SFR_ASSERT(a_event_src, clk, rst_n, $rose(out_valid_r) |-> $past(proc && term), "event without end run")

endmodule

`default_nettype wire

/* tb/sv/hmi_sfr_event_checker.sv */
// ---------------------------------------------------------------------------
// hmi serial frame receiver event checker
// watches both channels, tracks the frame state of every accepted byte beat,
// predicts the event of each completed frame and compares it with the
// event beats taken from the block, oldest first
// ---------------------------------------------------------------------------
module hmi_sfr_event_checker
  import hmi_sfr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  hmi_sfr_in_if  in_ch,
  hmi_sfr_out_if out_ch,
  output int     fail_total,
  output int     open_total,
  output int     event_total
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int END_RUN_LEN = 3;

  logic [7:0] frame_bytes [FRAME_DEPTH];
  int         frame_len = 0;
  int         ff_run = 0;
  event_t     awaited_events [$];
  int         errors = 0;
  int         seen = 0;

  initial begin
    for (int i = 0; i < FRAME_DEPTH; i++) frame_bytes[i] = 8'h00;
  end

  task add_frame_byte(input logic [7:0] b);
    if (frame_len < FRAME_DEPTH) begin
      frame_bytes[frame_len] = b;
      frame_len++;
    end
  endtask

  function event_t decode_frame();
    event_t ev;
    ev = '0;
    ev.kind = EV_NONE;
    if (frame_len == 1 && frame_bytes[0] == CODE_READY) begin
      ev.kind = EV_READY;
    end else if (frame_len == 4 && frame_bytes[0] == CODE_TOUCH) begin
      ev.kind   = EV_TOUCH;
      ev.page   = frame_bytes[1];
      ev.widget = frame_bytes[2];
      ev.press  = frame_bytes[3];
    end else if (frame_len == 3 && frame_bytes[0] == CODE_DEMO0 &&
                 frame_bytes[1] == CODE_DEMO1) begin
      if (frame_bytes[2] == CODE_TOGGLE) begin
        ev.kind = EV_DEMO_TOGGLE;
      end else if (frame_bytes[2] == CODE_RESET) begin
        ev.kind = EV_DEMO_RESET;
      end
    end
    return ev;
  endfunction

  task track_rx_byte(input logic [7:0] b);
    if (b == END_BYTE) begin
      ff_run++;
      if (ff_run >= END_RUN_LEN) begin
        awaited_events.push_back(decode_frame());
        frame_len = 0;
        ff_run    = 0;
      end
    end else begin
      while (ff_run > 0) begin
        add_frame_byte(END_BYTE);
        ff_run--;
      end
      // a data byte into a full frame drops the whole frame
      if (frame_len < FRAME_DEPTH) begin
        add_frame_byte(b);
      end else begin
        frame_len = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    event_t exp_ev;
    if (!rst_n) begin
      frame_len = 0;
      ff_run    = 0;
      awaited_events.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen++;
        if (awaited_events.size() == 0) begin
          errors++;
          $display("%0t unexpected event beat: expected none, got kind=%0d page=%02h widget=%02h press=%02h",
                   $time, out_ch.event_kind, out_ch.page_number, out_ch.widget_number,
                   out_ch.press_kind);
        end else begin
          exp_ev = awaited_events.pop_front();
          if (out_ch.event_kind !== exp_ev.kind || out_ch.page_number !== exp_ev.page ||
              out_ch.widget_number !== exp_ev.widget || out_ch.press_kind !== exp_ev.press) begin
            errors++;
            $display("%0t event mismatch: expected kind=%0d page=%02h widget=%02h press=%02h, got kind=%0d page=%02h widget=%02h press=%02h",
                     $time, exp_ev.kind, exp_ev.page, exp_ev.widget, exp_ev.press,
                     out_ch.event_kind, out_ch.page_number, out_ch.widget_number,
                     out_ch.press_kind);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        track_rx_byte(in_ch.rx_byte);
      end
    end
    fail_total  <= errors;
    open_total  <= awaited_events.size();
    event_total <= seen;
  end

endmodule

/* tb/sv/tb_top.sv */
// ---------------------------------------------------------------------------
// hmi serial frame receiver testbench top
// drives directed and random byte streams under idle and stall phases,
// holds the event side off once to fill the block, and gives the verdict
// from the event checker's failure and open-event counts
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hmi_sfr_pkg::*;

  localparam int RAND_ITEMS  = 1650;
  localparam int SEG_ITEMS   = 110;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_n;

  hmi_sfr_in_if  in_ch ();
  hmi_sfr_out_if out_ch ();

  int   chk_fails;
  int   chk_open;
  int   chk_events;

  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int   bytes_sent = 0;

  hmi_serial_frame_receiver_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hmi_sfr_event_checker CHK (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_total  (chk_fails),
    .open_total  (chk_open),
    .event_total (chk_events)
  );

  always #2ns clk = ~clk;

  initial begin
    #2ms;
    $display("timeout with %0d events still awaited", chk_open);
    $display("FAILURE");
    $finish;
  end

  // event side: random stalls, one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] any_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return END_BYTE;
    if (r < 30) begin
      case ($urandom_range(5))
        0: return CODE_READY;
        1: return CODE_TOUCH;
        2: return CODE_DEMO0;
        3: return CODE_DEMO1;
        4: return CODE_TOGGLE;
        default: return CODE_RESET;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] data_byte();
    return 8'($urandom_range(254));
  endfunction

  task automatic send_rx(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_term();
    repeat (3) send_rx(END_BYTE);
  endtask

  task automatic drain_events();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_open != 0) @(posedge clk);
  endtask

  task automatic send_random_frame();
    int pick;
    int n;
    int k;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_rx(CODE_READY);
      send_term();
    end else if (pick < 35) begin
      send_rx(CODE_TOUCH);
      repeat (3) send_rx(any_byte());
      send_term();
    end else if (pick < 50) begin
      send_rx(CODE_DEMO0);
      send_rx(CODE_DEMO1);
      k = $urandom_range(3);
      send_rx(k == 0 ? CODE_TOGGLE : (k == 1 ? CODE_RESET : any_byte()));
      send_term();
    end else if (pick < 63) begin
      n = $urandom_range(6);
      repeat (n) send_rx(any_byte());
      send_term();
    end else if (pick < 75) begin
      // run into the end of the frame store
      n = $urandom_range(FRAME_DEPTH + 2, FRAME_DEPTH - 3);
      repeat (n) send_rx(data_byte());
      k = $urandom_range(2);
      repeat (k) send_rx(END_BYTE);
      if ($urandom_range(1) == 1) send_rx(data_byte());
      send_term();
    end else if (pick < 87) begin
      // broken frame, no full terminator
      n = $urandom_range(3, 1);
      send_rx($urandom_range(1) == 1 ? CODE_TOUCH : CODE_DEMO0);
      repeat (n - 1) send_rx(any_byte());
      repeat ($urandom_range(2)) send_rx(END_BYTE);
    end else begin
      repeat ($urandom_range(5, 1)) send_rx(any_byte());
    end
  endtask

  initial begin
    int rand_goal;
    int seg_end;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    rst_n         <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty frame, each event, extreme bytes
    send_term();
    send_rx(CODE_READY);
    send_term();
    send_rx(CODE_TOUCH);
    send_rx(8'h00);
    send_rx(END_BYTE);
    send_rx(8'h80);
    send_term();
    send_rx(CODE_DEMO0);
    send_rx(CODE_DEMO1);
    send_rx(CODE_TOGGLE);
    send_term();
    send_rx(CODE_DEMO0);
    send_rx(CODE_DEMO1);
    send_rx(CODE_RESET);
    send_term();
    drain_events();

    rand_goal = bytes_sent + RAND_ITEMS;
    for (int seg = 0; bytes_sent < rand_goal; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (seg == 6) begin
        idle_pct  = 0;
        stall_pct = 0;
        hold_go  <= 1'b1;
        repeat (30) begin
          send_rx(CODE_READY);
          send_term();
        end
        drain_events();
      end
      seg_end = bytes_sent + SEG_ITEMS;
      while (bytes_sent < seg_end) send_random_frame();
      drain_events();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d byte beats and %0d event beats: all event kinds, full-frame drops,",
             bytes_sent, chk_events);
    $display("idle and stall phases and a %0d-cycle event hold-off", HOLD_CYCLES);
    if (chk_fails == 0 && chk_open == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
